@@ rtl/core/lsd_pkg.sv @@
package lsd_pkg;

    // History window and match geometry
    localparam int RING_DEPTH  = 4096;
    localparam int AW          = $clog2(RING_DEPTH);
    localparam int FILL_W      = AW + 1;
    localparam int MATCH_LIMIT = 18;
    localparam int MIN_MATCH   = MATCH_LIMIT - 15;
    localparam int START_POS   = RING_DEPTH - MATCH_LIMIT;
    localparam int LEN_W       = $clog2(MATCH_LIMIT + 1);

    // Byte counter and capacity register
    localparam int          CNT_W     = 25;
    localparam logic [24:0] CAP_RESET = 25'd16777216;

    // Register map: one 32-bit register per word
    localparam int         PADDR_W          = 3;
    localparam logic [0:0] REG_IDX_CAPACITY = 1'b0;

    // Command kinds passed from the parser to the copy engine
    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] b0;     // literal byte, or low position byte
        logic [7:0] b1;     // high position nibble and length nibble
        logic       last;   // final command of the stream
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic             stream_done;
        logic             overflow;
        logic             run_last;
        logic             data_valid;
        logic [7:0]       data_byte;
    } res_t;

endpackage

@@ rtl/core/lsd_front.sv @@
module lsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic          q_full,
    output logic          push,
    output lsd_pkg::cmd_t cmd
);
    import lsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FLAG = 3'b001,
        PH_UNIT = 3'b010,
        PH_REF2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] flag_reg, flag_next;
    logic [7:0] offs_reg, offs_next;
    logic [8:0] flag_shr;
    phase_t     unit_phase;
    logic       acc;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;

    // Remaining flag bits after one unit
    assign flag_shr   = {1'b0, flag_reg[8:1]};
    assign unit_phase = (|flag_shr[8:1]) ? PH_UNIT : PH_FLAG;

    // Token parser
    always_comb
    begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        offs_next  = offs_reg;
        push       = 1'b0;
        cmd.kind   = CMD_END;
        cmd.b0     = in_byte;
        cmd.b1     = in_byte;
        cmd.last   = in_last;
        if (acc)
        begin
            case (phase_reg)
                PH_UNIT:
                begin
                    if (flag_reg[0])
                    begin
                        push       = 1'b1;
                        cmd.kind   = CMD_LIT;
                        flag_next  = flag_shr;
                        phase_next = unit_phase;
                    end
                    else
                    begin
                        offs_next  = in_byte;
                        phase_next = PH_REF2;
                        push       = in_last;
                    end
                end
                PH_REF2:
                begin
                    push       = 1'b1;
                    cmd.kind   = CMD_COPY;
                    cmd.b0     = offs_reg;
                    flag_next  = flag_shr;
                    phase_next = unit_phase;
                end
                default:
                begin
                    flag_next  = {1'b1, in_byte};
                    phase_next = PH_UNIT;
                    push       = in_last;
                end
            endcase
            // End of stream drops any partial token
            if (in_last)
            begin
                phase_next = PH_FLAG;
                flag_next  = '0;
                offs_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            offs_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            offs_reg  <= offs_next;
        end
    end

endmodule

@@ rtl/core/lsd_cmd_fifo.sv @@
module lsd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lsd_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output lsd_pkg::cmd_t dout,
    output logic          empty
);
    import lsd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = cnt_reg[1];
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ rtl/core/lsd_back.sv @@
module lsd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lsd_pkg::cmd_t             cmd,
    input  logic                      q_empty,
    output logic                      pop,
    input  logic [lsd_pkg::CNT_W-1:0] capacity,
    output logic                      res_valid,
    input  logic                      res_ready,
    output lsd_pkg::res_t             res
);
    import lsd_pkg::*;

    typedef enum logic [1:0] {
        BE_IDLE = 2'b01,
        BE_COPY = 2'b10
    } be_state_t;

    be_state_t         st_reg, st_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic              last_reg, last_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic [7:0]        ring [RING_DEPTH];
    logic [7:0]        ring_q;
    logic              byp_reg;
    logic [7:0]        byp_data_reg;
    logic              hit_reg;

    logic              can_load, load, emit, is_final, stream_end, em_ok;
    logic              rd_en, wr_en, rd_byp, rd_hit;
    logic [AW-1:0]     rd_addr, rd_rel;
    logic [7:0]        wr_data, rd_data;
    res_t              res_c;

    assign can_load  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Ring read data: same-cycle write bypass, unwritten entries read as zero
    assign rd_data = byp_reg ? byp_data_reg : (hit_reg ? ring_q : 8'h00);

    // Command sequencer
    always_comb
    begin
        st_next     = st_reg;
        src_next    = src_reg;
        remain_next = remain_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = src_reg;
        load        = 1'b0;
        emit        = 1'b0;
        is_final    = 1'b0;
        stream_end  = 1'b0;
        wr_data     = rd_data;
        case (st_reg)
            BE_IDLE:
            begin
                if (!q_empty)
                begin
                    case (cmd.kind)
                        CMD_LIT:
                        begin
                            if (can_load)
                            begin
                                pop        = 1'b1;
                                load       = 1'b1;
                                emit       = 1'b1;
                                wr_data    = cmd.b0;
                                is_final   = 1'b1;
                                stream_end = cmd.last;
                            end
                        end
                        CMD_COPY:
                        begin
                            pop         = 1'b1;
                            rd_en       = 1'b1;
                            rd_addr     = {cmd.b1[7:4], cmd.b0};
                            src_next    = rd_addr + AW'(1);
                            remain_next = LEN_W'(cmd.b1[3:0]) + LEN_W'(MIN_MATCH);
                            last_next   = cmd.last;
                            st_next     = BE_COPY;
                        end
                        default:
                        begin
                            if (can_load)
                            begin
                                pop        = 1'b1;
                                load       = 1'b1;
                                is_final   = 1'b1;
                                stream_end = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BE_COPY:
            begin
                if (can_load)
                begin
                    load = 1'b1;
                    emit = 1'b1;
                    if (remain_reg == LEN_W'(1))
                    begin
                        is_final   = 1'b1;
                        stream_end = last_reg;
                        st_next    = BE_IDLE;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = src_reg;
                        src_next    = src_reg + AW'(1);
                        remain_next = remain_reg - LEN_W'(1);
                    end
                end
            end
            default:
            begin
                st_next = BE_IDLE;
            end
        endcase
    end

    assign wr_en = emit;

    // Read hit: entry already written in this stream, or written this cycle
    assign rd_rel = rd_addr - AW'(START_POS);
    assign rd_hit = {1'b0, rd_rel} < fill_reg;
    assign rd_byp = wr_en && (rd_addr == wp_reg);

    // Result build and stream counters
    assign em_ok = !ovf_reg && (count_reg < capacity);

    always_comb
    begin
        res_c.data_valid  = emit && em_ok;
        res_c.data_byte   = (emit && em_ok) ? wr_data : 8'h00;
        res_c.run_last    = is_final;
        res_c.overflow    = ovf_reg || (emit && !em_ok);
        res_c.stream_done = stream_end;
        res_c.byte_count  = count_reg + CNT_W'(emit && em_ok);

        wp_next    = wp_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (emit)
        begin
            wp_next    = wp_reg + AW'(1);
            fill_next  = (fill_reg == FILL_W'(RING_DEPTH)) ? fill_reg : fill_reg + FILL_W'(1);
            count_next = res_c.byte_count;
            ovf_next   = res_c.overflow;
        end
        if (stream_end)
        begin
            wp_next    = AW'(START_POS);
            fill_next  = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end

        out_valid_next = load ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
        out_next       = load ? res_c : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BE_IDLE;
            remain_reg    <= '0;
            last_reg      <= 1'b0;
            wp_reg        <= AW'(START_POS);
            fill_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            remain_reg    <= remain_next;
            last_reg      <= last_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (rd_en)
            begin
                byp_reg <= rd_byp;
                hit_reg <= rd_hit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        out_reg <= out_next;
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    // History ring
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ring_q <= ring[rd_addr];
        end
    end

endmodule

@@ rtl/core/lzss_stream_decoder_core.sv @@
// LZSS stream decoder, 4096-byte window, matches of 3 to 18 bytes.
// Compressed bytes enter on the s_ channel (s_tlast marks the final byte of
// a stream); decoded results leave on the m_ channel, one per decoded byte.
// m_tlast marks the last result caused by an input byte; m_tuser carries
// data_valid, overflow and stream_done. A flag byte or a first offset byte
// gives no result unless it ends the stream, in which case one empty result
// carries stream_done and the final count.
// A literal is stored in the command queue, then loaded into the result register on m_.
// A back-reference gets one ring read to prime the copy engine, then one byte per cycle
// while m_tready stays high; the ring has a single read port.
// Throughput: up to one result per cycle while m_tready stays high.
// The parser and copy engine are split by a 2-entry command queue, so input
// keeps flowing while the engine copies and while a result waits at m_.
// When m_tready is low the result register holds and the engine stops;
// the parser fills the queue and then drops s_tready.
// Reset (or the end of a stream) restarts at write position 4078 with an
// empty ring; a fill count masks stale entries, so no clearing pass runs.
// The capacity register sits at address 0 of the APB port.
module lzss_stream_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] in_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // [7:0] data_byte, [32:8] byte_count
    output logic                        m_tlast,
    output logic [2:0]                  m_tuser    // [0] data_valid, [1] overflow, [2] stream_done
);
    import lsd_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    logic             cfg_wr, cfg_sel;
    logic             q_full, q_empty, q_push, q_pop;
    cmd_t             fe_cmd, q_head;
    res_t             res;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_IDX_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? {{(32 - CNT_W){1'b0}}, cap_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Token parser
    lsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (fe_cmd)
    );

    // Command queue
    lsd_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (fe_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    // Copy engine with history ring
    lsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .capacity  (cap_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{(40 - CNT_W - 8){1'b0}}, res.byte_count, res.data_byte};
    assign m_tlast = res.run_last;
    assign m_tuser = {res.stream_done, res.overflow, res.data_valid};

`ifndef SYNTHESIS
    // Stream end is always the last result of its input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.stream_done |-> res.run_last)
        else $error("stream_done without run_last");

    // Delivered data never coexists with the overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.data_valid |-> !res.overflow)
        else $error("data delivered after overflow");

    // Delivered byte count stays within the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.data_valid |-> res.byte_count <= cap_reg)
        else $error("byte count beyond capacity");

    // The parser never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overrun");
`endif

endmodule
